// ===== hdl/stc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// Shared constants, codes and controller/datapath interface types for the
// sprite tile slot cache.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int SLOT_COUNT_DEF = 24;

  localparam int KEY_W    = 16;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;
  localparam int OP_W     = 2;

  localparam logic [KEY_W-1:0] TAG_INVALID = 16'hFFFF;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
  localparam logic [OP_W-1:0] OP_NEW_FRAME  = 2'd1;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_FULL_CLEAR = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic accept_lookup;  // latch key, restart scan and probe counters
    logic clr_used;
    logic inval;
    logic clr_ptr;
    logic scan_en;
    logic probe_en;
    logic load_out;
  } stc_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_miss;
    logic alloc;
    logic full;
    logic out_free;
  } stc_sts_t;

endpackage
`default_nettype wire

// ===== hdl/stc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer for the slot cache: accepts a word; a lookup runs the tag scan,
// then the victim probe on a miss, then hands the result to the output register.
// ----------------------------------------------------------------------------
module stc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [stc_pkg::OP_W-1:0] in_opcode,
  output logic                         in_stall,
  input  wire stc_pkg::stc_sts_t       sts,
  output stc_pkg::stc_cmd_t            cmd
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_PROBE   = 4'b0100,
    S_DELIVER = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            stc_pkg::OP_LOOKUP: begin
              cmd.accept_lookup = 1'b1;
              state_nxt         = S_SCAN;
            end
            stc_pkg::OP_NEW_FRAME: begin
              cmd.clr_used = 1'b1;
            end
            stc_pkg::OP_INVALIDATE: begin
              cmd.inval = 1'b1;
            end
            stc_pkg::OP_FULL_CLEAR: begin
              cmd.inval    = 1'b1;
              cmd.clr_used = 1'b1;
              cmd.clr_ptr  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.hit) begin
          state_nxt = S_DELIVER;
        end else if (sts.scan_miss) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe_en = 1'b1;
        if (sts.alloc || sts.full) begin
          state_nxt = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/stc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stc_dp
// Slot cache datapath: tag memory with registered read, valid/used bits,
// victim pointer, upload counter and the output register.
// ----------------------------------------------------------------------------
module stc_dp #(
  parameter int SLOT_COUNT = stc_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [stc_pkg::KEY_W-1:0]     in_key_top,
  input  wire logic [stc_pkg::KEY_W-1:0]     in_key_bottom,
  input  wire stc_pkg::stc_cmd_t             cmd,
  output stc_pkg::stc_sts_t                  sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stc_pkg::SLOT_W-1:0]         out_slot_index,
  output logic [stc_pkg::STATUS_W-1:0]       out_status,
  output logic [stc_pkg::COUNT_W-1:0]        out_upload_count
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TAG_W = 2 * stc_pkg::KEY_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // tag memory: {top, bottom}; entries without valid bit read as invalid tags
  logic [TAG_W-1:0] tag_mem [SLOT_COUNT];
  logic [TAG_W-1:0] rd_data_r;

  logic [SLOT_COUNT-1:0] valid_r;
  logic [SLOT_COUNT-1:0] used_r;

  logic [stc_pkg::KEY_W-1:0] key_top_r;
  logic [stc_pkg::KEY_W-1:0] key_bot_r;

  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] probe_cnt_r;
  logic [IDX_W-1:0] ptr_r;
  logic [stc_pkg::COUNT_W-1:0] cnt_r;

  logic [IDX_W-1:0]             res_idx_r;
  logic [stc_pkg::STATUS_W-1:0] res_status_r;

  logic                          out_valid_r;
  logic [stc_pkg::SLOT_W-1:0]    out_slot_r;
  logic [stc_pkg::STATUS_W-1:0]  out_status_r;
  logic [stc_pkg::COUNT_W-1:0]   out_count_r;

  logic [stc_pkg::KEY_W-1:0] eff_top;
  logic [stc_pkg::KEY_W-1:0] eff_bot;
  logic match;
  logic hit;
  logic scan_miss;
  logic slot_free;
  logic alloc;
  logic full;
  logic [IDX_W-1:0] ptr_inc;

  // compare stage looks at the slot read in the previous cycle
  assign eff_top = valid_r[cmp_idx_r] ? rd_data_r[TAG_W-1:stc_pkg::KEY_W]
                                      : stc_pkg::TAG_INVALID;
  assign eff_bot = valid_r[cmp_idx_r] ? rd_data_r[stc_pkg::KEY_W-1:0]
                                      : stc_pkg::TAG_INVALID;
  assign match     = (eff_top == key_top_r) && (eff_bot == key_bot_r);
  assign hit       = cmd.scan_en && cmp_vld_r && match;
  assign scan_miss = cmd.scan_en && cmp_vld_r && !match && (cmp_idx_r == LAST_IDX);

  assign slot_free = !used_r[ptr_r];
  assign alloc     = cmd.probe_en && slot_free;
  assign full      = cmd.probe_en && !slot_free && (probe_cnt_r == LAST_IDX);
  assign ptr_inc   = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;

  assign sts.hit       = hit;
  assign sts.scan_miss = scan_miss;
  assign sts.alloc     = alloc;
  assign sts.full      = full;
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (alloc) begin
      tag_mem[ptr_r] <= {key_top_r, key_bot_r};
    end
    rd_data_r <= tag_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_lookup) begin
      key_top_r <= in_key_top;
      key_bot_r <= in_key_bottom;
    end
    if (hit) begin
      res_idx_r    <= cmp_idx_r;
      res_status_r <= stc_pkg::ST_HIT;
    end else if (alloc) begin
      res_idx_r    <= ptr_r;
      res_status_r <= stc_pkg::ST_ALLOC;
    end else if (full) begin
      res_idx_r    <= '0;
      res_status_r <= stc_pkg::ST_FULL;
    end
    if (cmd.load_out) begin
      out_slot_r   <= stc_pkg::SLOT_W'(res_idx_r);
      out_status_r <= res_status_r;
      out_count_r  <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      used_r      <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      cmp_idx_r   <= '0;
      cmp_vld_r   <= 1'b0;
      probe_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.inval) begin
        valid_r <= '0;
      end else if (alloc) begin
        valid_r[ptr_r] <= 1'b1;
      end

      if (cmd.clr_used) begin
        used_r <= '0;
      end else if (hit) begin
        used_r[cmp_idx_r] <= 1'b1;
      end else if (alloc) begin
        used_r[ptr_r] <= 1'b1;
      end

      if (cmd.clr_ptr) begin
        ptr_r <= '0;
      end else if (cmd.probe_en) begin
        ptr_r <= ptr_inc;
      end

      if (alloc) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (cmd.accept_lookup) begin
        rd_idx_r    <= '0;
        cmp_vld_r   <= 1'b0;
        probe_cnt_r <= '0;
      end else begin
        if (cmd.scan_en) begin
          // read index parks on the last slot; the scan leaves before reuse
          rd_idx_r  <= (rd_idx_r == LAST_IDX) ? rd_idx_r : rd_idx_r + 1'b1;
          cmp_idx_r <= rd_idx_r;
          cmp_vld_r <= 1'b1;
        end
        if (cmd.probe_en) begin
          probe_cnt_r <= probe_cnt_r + 1'b1;
        end
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_index   = out_slot_r;
  assign out_status       = out_status_r;
  assign out_upload_count = out_count_r;

endmodule
`default_nettype wire

// ===== hdl/sprite_tile_slot_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_tile_slot_cache
// Fully associative tile-pair slot cache with rotating victim allocation.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | opcode, key_top, key_bottom
//   out_    | output    | out_valid/out_stall | slot_index, status, upload_count
//
// Non-lookup words complete in the cycle they are accepted, with no result.
// A lookup scans the slots in order until a tag matches; on a miss it probes
// victims from the pointer until a free slot is found or every slot is used.
// The single read port of the tag memory sets the one-slot-per-cycle scan.
// Synchronous reset: all tags invalid, used marks, pointer and counter cleared.
// in_stall is high while a lookup is in flight. out_stall holds the result
// register and a finished lookup; a new word is taken while a result waits.
// ----------------------------------------------------------------------------
module sprite_tile_slot_cache #(
  parameter int SLOT_COUNT = stc_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [stc_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [stc_pkg::KEY_W-1:0]     in_key_top,
  input  wire logic [stc_pkg::KEY_W-1:0]     in_key_bottom,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stc_pkg::SLOT_W-1:0]         out_slot_index,
  output logic [stc_pkg::STATUS_W-1:0]       out_status,
  output logic [stc_pkg::COUNT_W-1:0]        out_upload_count
);

  stc_pkg::stc_cmd_t cmd;
  stc_pkg::stc_sts_t sts;

  stc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  stc_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_key_top       (in_key_top),
    .in_key_bottom    (in_key_bottom),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot_index   (out_slot_index),
    .out_status       (out_status),
    .out_upload_count (out_upload_count)
  );

`ifndef SYNTHESIS
  // a lookup word closes the input until its result is loaded
  a_lookup_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == stc_pkg::OP_LOOKUP) |=> in_stall)
    else $error("input reopened right after a lookup");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == stc_pkg::ST_FULL) |-> (out_slot_index == '0))
    else $error("no-free-slot result with nonzero slot");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == stc_pkg::ST_HIT) || (out_status == stc_pkg::ST_ALLOC) ||
                  (out_status == stc_pkg::ST_FULL))
    else $error("bad result status");
`endif

endmodule
`default_nettype wire
